// ===== rtl/lbp_3x3_texture_code_macros.svh =====
// Assertion macros for the 3x3 LBP texture code block.
// Used by the port checker; expects clk and rst_n in the including scope.
`ifndef LBP_3X3_TEXTURE_CODE_MACROS_SVH
`define LBP_3X3_TEXTURE_CODE_MACROS_SVH

// Same-cycle implication, off while in reset.
`define LBP_CHECK_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("lbp port check failed");

// Next-cycle implication, off while in reset.
`define LBP_CHECK_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lbp port check failed");

// Next-cycle implication that also runs during reset.
`define LBP_CHECK_ALWAYS_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("lbp port check failed");

`endif

// ===== rtl/lbp_pkg.sv =====
// Shared types, constants and the code function of the 3x3 LBP block.
// No dependencies; used by the line store, the top level and the checker.
`default_nettype none

package lbp_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int PIX_W      = 8;
  localparam int CODE_W     = 8;
  localparam int CFG_W_W    = 12;
  localparam int CFG_H_W    = 13;
  localparam int CFG_DATA_W = 13;
  // row counters must hold height + 1 for the largest height register value
  localparam int ROW_W      = 14;

  localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t pixel;
    logic flush;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] lbp_code;
    logic              row_last;
    logic              frame_last;
  } out_word_t;

  // one window column, top to bottom
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // bit 7 top-left, then clockwise, bit 0 left
  function automatic logic [CODE_W-1:0] window_code(col_t wl, col_t wc, col_t wr);
    pix_t c;
    c = wc.mid;
    window_code = {wl.top >= c, wc.top >= c, wr.top >= c, wr.mid >= c,
                   wr.bot >= c, wc.bot >= c, wl.bot >= c, wl.mid >= c};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lbp_line_store.sv =====
// Upper and middle row stores of the LBP block, one read and one write a cycle.
// Read data is registered; a write to the address read in the same cycle is forwarded.
// Depends on lbp_pkg.
`default_nettype none

module lbp_line_store #(
  parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  wire lbp_pkg::pix_t                wr_upper,
  input  wire lbp_pkg::pix_t                wr_middle,
  output lbp_pkg::pix_t                     rd_upper,
  output lbp_pkg::pix_t                     rd_middle
);

  lbp_pkg::pix_t upper_mem  [MAX_WIDTH];
  lbp_pkg::pix_t middle_mem [MAX_WIDTH];

  lbp_pkg::pix_t upper_q_r;
  lbp_pkg::pix_t middle_q_r;
  lbp_pkg::pix_t fwd_upper_r;
  lbp_pkg::pix_t fwd_middle_r;
  logic          fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_q_r    <= upper_mem[rd_addr];
      middle_q_r   <= middle_mem[rd_addr];
      fwd_upper_r  <= wr_upper;
      fwd_middle_r <= wr_middle;
    end
  end

  // the array read returns the old entry when the same address is written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_upper  = fwd_r ? fwd_upper_r  : upper_q_r;
  assign rd_middle = fwd_r ? fwd_middle_r : middle_q_r;

endmodule

`default_nettype wire

// ===== rtl/lbp_3x3_texture_code.sv =====
// 3x3 LBP code: one pixel word accepted per clock, sustained, while the output side flows.
// A result is in the output register once the word that completes its window leaves the window stage register;
// a pixel's code trails that pixel by image_width+1 words (window through two row stores).
// Throughput is set by the row stores: one read and one write per store per cycle.
// Reset (rst_n low, synchronous): counters, window and output valid clear, width 640,
// height 480; the row stores are not cleared and need no clearing pass.
`default_nettype none

module lbp_3x3_texture_code #(
  parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire lbp_pkg::in_word_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output lbp_pkg::out_word_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire lbp_pkg::cfg_index_t               cfg_index,
  input  wire logic [lbp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = ($clog2(MAX_WIDTH + 1) > lbp_pkg::CFG_W_W) ?
                         $clog2(MAX_WIDTH + 1) : lbp_pkg::CFG_W_W;
  localparam int ROW_W = lbp_pkg::ROW_W;

  // configuration
  logic [lbp_pkg::CFG_W_W-1:0] cfg_width_r;
  logic [lbp_pkg::CFG_H_W-1:0] cfg_height_r;

  // frame counters
  logic [COL_W-1:0] in_col_r,  in_col_nxt;
  logic [ROW_W-1:0] in_row_r,  in_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;

  // window stage register
  logic          b_valid_r;
  lbp_pkg::pix_t b_pix_r;
  logic [COL_W-1:0] b_idx_r;
  logic          b_col0_r;
  logic          b_use_up_r;
  logic          b_use_mid_r;
  logic          b_emit_r;
  logic          b_row_last_r;
  logic          b_frame_last_r;

  lbp_pkg::col_t win_l_r, win_l_nxt;
  lbp_pkg::col_t win_c_r, win_c_nxt;

  logic               out_valid_r;
  lbp_pkg::out_word_t out_data_r;

  // accept-side decode
  logic [CMP_W-1:0] w_raw, w_eff;
  logic [ROW_W-1:0] h_raw, h_eff;
  logic             wrap;
  logic [COL_W-1:0] a_col;
  logic [ROW_W-1:0] a_row;
  logic             a_col0;
  logic             a_use_up;
  logic             a_use_mid;
  lbp_pkg::pix_t    a_pix;
  logic             a_emit;
  logic             a_row_last;
  logic             a_frame_last;
  logic             a_col_end;

  logic in_fire;
  logic b_fire;
  logic out_free;

  lbp_pkg::pix_t up_raw, mid_raw;
  lbp_pkg::pix_t b_up, b_mid;
  lbp_pkg::col_t b_new, b_rgt;
  logic [lbp_pkg::CODE_W-1:0] b_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= lbp_pkg::WIDTH_RESET;
      cfg_height_r <= lbp_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lbp_pkg::CFG_IMAGE_WIDTH:  cfg_width_r  <= cfg_wdata[lbp_pkg::CFG_W_W-1:0];
        lbp_pkg::CFG_IMAGE_HEIGHT: cfg_height_r <= cfg_wdata[lbp_pkg::CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp sizes: width to 1..MAX_WIDTH, height to at least 1
  assign w_raw = CMP_W'(cfg_width_r);
  assign h_raw = ROW_W'(cfg_height_r);

  always_comb begin
    if (w_raw == '0) begin
      w_eff = CMP_W'(1);
    end else if (w_raw > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
  end

  assign h_eff = (h_raw == '0) ? ROW_W'(1) : h_raw;

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign b_fire   = b_valid_r && (!b_emit_r || out_free);
  assign in_stall = b_valid_r && !b_fire;

  // column and row of the word being accepted
  assign wrap   = CMP_W'(in_col_r) >= w_eff;
  assign a_col  = wrap ? '0 : in_col_r;
  assign a_row  = wrap ? in_row_r + ROW_W'(1) : in_row_r;
  assign a_col0 = (a_col == '0);

  assign a_use_up  = (a_row >= ROW_W'(2)) && (a_row < h_eff + ROW_W'(2));
  assign a_use_mid = (a_row >= ROW_W'(1)) && (a_row < h_eff + ROW_W'(1));
  assign a_pix     = ((a_row < h_eff) && !in_data.flush) ? in_data.pixel : '0;

  // column 0 finishes the previous row's last centre
  assign a_emit       = a_col0 ? (a_row >= ROW_W'(2)) : (a_row >= ROW_W'(1));
  assign a_row_last   = (CMP_W'(out_col_r) + CMP_W'(1)) >= w_eff;
  assign a_frame_last = a_row_last && ((out_row_r + ROW_W'(1)) >= h_eff);
  assign a_col_end    = (CMP_W'(a_col) + CMP_W'(1)) >= w_eff;

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (a_emit && a_frame_last) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else begin
      if (a_col_end) begin
        in_col_nxt = '0;
        in_row_nxt = a_row + ROW_W'(1);
      end else begin
        in_col_nxt = COL_W'(CMP_W'(a_col) + CMP_W'(1));
        in_row_nxt = a_row;
      end
      if (a_emit) begin
        if (a_row_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (in_fire) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_fire) begin
      b_valid_r <= 1'b1;
    end else if (b_fire) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_pix_r        <= a_pix;
      b_idx_r        <= a_col;
      b_col0_r       <= a_col0;
      b_use_up_r     <= a_use_up;
      b_use_mid_r    <= a_use_mid;
      b_emit_r       <= a_emit;
      b_row_last_r   <= a_row_last;
      b_frame_last_r <= a_frame_last;
    end
  end

  lbp_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .rd_addr   (a_col),
    .wr_en     (b_fire),
    .wr_addr   (b_idx_r),
    .wr_upper  (b_mid),
    .wr_middle (b_pix_r),
    .rd_upper  (up_raw),
    .rd_middle (mid_raw)
  );

  // rows above the frame and past its drain read as zero
  assign b_up  = b_use_up_r  ? up_raw  : '0;
  assign b_mid = b_use_mid_r ? mid_raw : '0;
  assign b_new = '{top: b_up, mid: b_mid, bot: b_pix_r};
  assign b_rgt = b_col0_r ? '0 : b_new;

  assign b_code = lbp_pkg::window_code(win_l_r, win_c_r, b_rgt);

  always_comb begin
    if (b_emit_r && b_frame_last_r) begin
      win_l_nxt = '0;
      win_c_nxt = '0;
    end else if (b_col0_r) begin
      win_l_nxt = '0;
      win_c_nxt = b_new;
    end else begin
      win_l_nxt = win_c_r;
      win_c_nxt = b_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_l_r <= '0;
      win_c_r <= '0;
    end else if (b_fire) begin
      win_l_r <= win_l_nxt;
      win_c_r <= win_c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_fire && b_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_emit_r) begin
      out_data_r.lbp_code   <= b_code;
      out_data_r.row_last   <= b_row_last_r;
      out_data_r.frame_last <= b_frame_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/lbp_checker.sv =====
// Port-level checks for the 3x3 LBP block, bound to the top level.
// Depends on lbp_pkg and lbp_3x3_texture_code_macros.svh.
`default_nettype none

module lbp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire lbp_pkg::in_word_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire lbp_pkg::out_word_t out_data
);

`include "lbp_3x3_texture_code_macros.svh"

  // hold a stalled result word
  `LBP_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // the input side stalls only behind a blocked result word
  `LBP_CHECK_NOW(a_stall_cause, in_valid && in_stall, out_valid && out_stall)

  // frame end always closes a row
  `LBP_CHECK_NOW(a_frame_row, out_valid && out_data.frame_last, out_data.row_last)

  // drop results on reset
  `LBP_CHECK_ALWAYS_NEXT(a_reset_idle, !rst_n, !out_valid)

endmodule

bind lbp_3x3_texture_code lbp_checker u_lbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
